// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on aclk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rrl_pkg.sv =====
package rrl_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int ADDR_BITS_DEF = 48;

    localparam int CMD_W        = 2;
    localparam int HANDLE_W     = 16;
    localparam int FIELD_ADDR_W = 48;
    localparam int SIZE_W       = 19;
    localparam int LEN_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    localparam int CMD_LSB    = 0;
    localparam int HANDLE_LSB = CMD_LSB + CMD_W;
    localparam int RBASE_LSB  = HANDLE_LSB + HANDLE_W;
    localparam int RSIZE_LSB  = RBASE_LSB + FIELD_ADDR_W;
    localparam int QADDR_LSB  = RSIZE_LSB + SIZE_W;
    localparam int QLEN_LSB   = QADDR_LSB + FIELD_ADDR_W;
    localparam int S_BITS     = QLEN_LSB + LEN_W;
    localparam int S_TDATA_W  = ((S_BITS + 7) / 8) * 8;

    localparam int STATUS_LSB = 0;
    localparam int OWNER_LSB  = STATUS_LSB + STATUS_W;
    localparam int COUNT_LSB  = OWNER_LSB + HANDLE_W;
    localparam int M_BITS     = COUNT_LSB + COUNT_W;
    localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_HANDLE = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_REMOVE,
        OP_FIND
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] handle;
    } bus_t;

    typedef struct packed {
        logic                valid;
        logic                done;
        logic [HANDLE_W-1:0] owner;
    } tok_t;

endpackage

// ===== rtl/region_registry_lookup_top.sv =====
// One command at a time: on accept a token walks the cell row, one cell a cycle; the result
// is then registered and moves to the output register once that is free, before the next accept.
// Input is taken again while a finished result still waits on the output register.
// Reset (aresetn low, synchronous) empties the table and drops any command in flight;
// the entry storage itself is not cleared.
module region_registry_lookup_top #(
    parameter int SLOTS     = rrl_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = rrl_pkg::ADDR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // cmd, handle, region_base, region_size, query_addr, query_len
    input  logic [rrl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // status, owner_handle, entry_count
    output logic [rrl_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import rrl_pkg::*;

    localparam int AW = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
    localparam int CW = $clog2(SLOTS + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                start_reg, start_next;
    logic [CMD_W-1:0]    cmd_reg,   cmd_next;
    bus_t                bus_reg,   bus_next;
    logic [AW-1:0]       rbase_reg, rbase_next;
    logic [SIZE_W-1:0]   rsize_reg, rsize_next;
    logic [AW-1:0]       qa_reg,    qa_next;
    logic [AW:0]         qend_reg,  qend_next;
    logic [M_BITS-1:0]   res_reg,   res_next;
    logic                mval_reg,  mval_next;
    logic [M_BITS-1:0]   mdat_reg,  mdat_next;

    logic [CMD_W-1:0]    in_cmd;
    logic [HANDLE_W-1:0] in_handle;
    logic [AW-1:0]       in_qa;
    logic [LEN_W-1:0]    in_ql;
    logic [AW:0]         in_qend;
    logic                in_wrap;
    op_t                 in_op;
    status_e             res_status;
    logic [HANDLE_W-1:0] res_owner;
    logic [CW-1:0]       res_count;

    tok_t                tok [SLOTS+1];
    logic [AW-1:0]       ent_base  [SLOTS];
    logic [SIZE_W-1:0]   ent_size  [SLOTS];
    logic [HANDLE_W-1:0] ent_owner [SLOTS];

    assign in_cmd    = s_tdata[CMD_LSB +: CMD_W];
    assign in_handle = s_tdata[HANDLE_LSB +: HANDLE_W];
    assign in_qa     = s_tdata[QADDR_LSB +: AW];
    assign in_ql     = s_tdata[QLEN_LSB +: LEN_W];
    assign in_qend   = {1'b0, in_qa} + (AW+1)'(in_ql);
    assign in_wrap   = (ADDR_BITS <= FIELD_ADDR_W) ? in_qend[AW] : 1'b0;

    always_comb begin
        in_op = OP_NONE;
        case (in_cmd)
            CMD_ADD: begin
                if (in_handle != '0 && count_reg != CW'(SLOTS)) begin
                    in_op = OP_ADD;
                end
            end
            CMD_REMOVE: begin
                if (in_handle != '0) begin
                    in_op = OP_REMOVE;
                end
            end
            CMD_FIND: begin
                if (in_qa != '0 && !in_wrap) begin
                    in_op = OP_FIND;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_status = ST_NOT_FOUND;
        res_owner  = '0;
        res_count  = count_reg;
        case (cmd_reg)
            CMD_ADD: begin
                if (bus_reg.handle == '0) begin
                    res_status = ST_BAD_HANDLE;
                end else if (count_reg == CW'(SLOTS)) begin
                    res_status = ST_FULL;
                end else begin
                    res_status = ST_OK;
                    res_count  = count_reg + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (bus_reg.handle == '0) begin
                    res_status = ST_BAD_HANDLE;
                end else if (tok[SLOTS].done) begin
                    res_status = ST_OK;
                    res_count  = count_reg - 1'b1;
                end
            end
            CMD_FIND: begin
                if (tok[SLOTS].done) begin
                    res_status = ST_OK;
                    res_owner  = tok[SLOTS].owner;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        start_next = 1'b0;
        cmd_next   = cmd_reg;
        bus_next   = bus_reg;
        rbase_next = rbase_reg;
        rsize_next = rsize_reg;
        qa_next    = qa_reg;
        qend_next  = qend_reg;
        res_next   = res_reg;
        mval_next  = mval_reg;
        mdat_next  = mdat_reg;
        s_tready   = 1'b0;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    start_next   = 1'b1;
                    cmd_next     = in_cmd;
                    bus_next.op  = in_op;
                    bus_next.handle = in_handle;
                    rbase_next   = s_tdata[RBASE_LSB +: AW];
                    rsize_next   = s_tdata[RSIZE_LSB +: SIZE_W];
                    qa_next      = in_qa;
                    qend_next    = in_qend;
                    state_next   = S_RUN;
                end
            end
            S_RUN: begin
                if (tok[SLOTS].valid) begin
                    count_next = res_count;
                    res_next   = {COUNT_W'(res_count), res_owner, res_status};
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdat_next  = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        bus_reg   <= bus_next;
        rbase_reg <= rbase_next;
        rsize_reg <= rsize_next;
        qa_reg    <= qa_next;
        qend_reg  <= qend_next;
        res_reg   <= res_next;
        mdat_reg  <= mdat_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            start_reg <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= start_next;
            mval_reg  <= mval_next;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = M_TDATA_W'(mdat_reg);

    assign tok[0] = '{valid: start_reg, done: 1'b0, owner: '0};

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic [AW-1:0]       nb_base;
        logic [SIZE_W-1:0]   nb_size;
        logic [HANDLE_W-1:0] nb_owner;

        if (i == SLOTS - 1) begin : g_last
            assign nb_base  = '0;
            assign nb_size  = '0;
            assign nb_owner = '0;
        end else begin : g_mid
            assign nb_base  = ent_base[i+1];
            assign nb_size  = ent_size[i+1];
            assign nb_owner = ent_owner[i+1];
        end

        rrl_cell #(
            .AW  (AW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .bus_i      (bus_reg),
            .count_i    (count_reg),
            .add_base_i (rbase_reg),
            .add_size_i (rsize_reg),
            .q_addr_i   (qa_reg),
            .q_end_i    (qend_reg),
            .tok_i      (tok[i]),
            .tok_o      (tok[i+1]),
            .nb_base_i  (nb_base),
            .nb_size_i  (nb_size),
            .nb_owner_i (nb_owner),
            .base_o     (ent_base[i]),
            .size_o     (ent_size[i]),
            .owner_o    (ent_owner[i])
        );
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_range, count_reg <= CW'(SLOTS))
    `ASSERT_IMPLIES(a_tok_in_run, tok[SLOTS].valid, state_reg == S_RUN)
    `ASSERT_IMPLIES(a_count_at_exit, count_reg != $past(count_reg), $past(tok[SLOTS].valid))
    `ASSERT_IMPLIES(a_one_token, start_reg, !tok[SLOTS].valid && state_reg == S_RUN)

endmodule

// ===== rtl/rrl_cell.sv =====
module rrl_cell #(
    parameter int AW  = 48,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rrl_pkg::bus_t                   bus_i,
    input  logic [CW-1:0]                   count_i,
    input  logic [AW-1:0]                   add_base_i,
    input  logic [rrl_pkg::SIZE_W-1:0]      add_size_i,
    input  logic [AW-1:0]                   q_addr_i,
    input  logic [AW:0]                     q_end_i,
    input  rrl_pkg::tok_t                   tok_i,
    output rrl_pkg::tok_t                   tok_o,
    input  logic [AW-1:0]                   nb_base_i,
    input  logic [rrl_pkg::SIZE_W-1:0]      nb_size_i,
    input  logic [rrl_pkg::HANDLE_W-1:0]    nb_owner_i,
    output logic [AW-1:0]                   base_o,
    output logic [rrl_pkg::SIZE_W-1:0]      size_o,
    output logic [rrl_pkg::HANDLE_W-1:0]    owner_o
);
    import rrl_pkg::*;

    logic [AW-1:0]       base_reg,  base_next;
    logic [SIZE_W-1:0]   size_reg,  size_next;
    logic [HANDLE_W-1:0] owner_reg, owner_next;
    tok_t                tok_reg,   tok_next;
    logic                live;
    logic                slot_here;
    logic [AW:0]         region_end;
    logic                holds;

    assign live       = CW'(IDX) < count_i;
    assign slot_here  = count_i == CW'(IDX);
    assign region_end = {1'b0, base_reg} + (AW+1)'(size_reg);
    assign holds      = (q_addr_i >= base_reg) && (q_end_i <= region_end);

    always_comb begin
        tok_next   = tok_i;
        base_next  = base_reg;
        size_next  = size_reg;
        owner_next = owner_reg;
        if (tok_i.valid) begin
            case (bus_i.op)
                OP_ADD: begin
                    if (slot_here) begin
                        base_next  = add_base_i;
                        size_next  = add_size_i;
                        owner_next = bus_i.handle;
                    end
                end
                OP_REMOVE: begin
                    if (live && (tok_i.done || owner_reg == bus_i.handle)) begin
                        // close the gap: take the neighbour's entry
                        tok_next.done = 1'b1;
                        base_next     = nb_base_i;
                        size_next     = nb_size_i;
                        owner_next    = nb_owner_i;
                    end
                end
                OP_FIND: begin
                    if (live && !tok_i.done && holds) begin
                        tok_next.done  = 1'b1;
                        tok_next.owner = owner_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        base_reg  <= base_next;
        size_reg  <= size_next;
        owner_reg <= owner_next;
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_o   = tok_reg;
    assign base_o  = base_reg;
    assign size_o  = size_reg;
    assign owner_o = owner_reg;

endmodule

// ===== test/region_registry_lookup_top_tb.sv =====
module region_registry_lookup_top_tb;
    import rrl_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int ADDR_BITS      = ADDR_BITS_DEF;
    localparam int ITEMS_PER_RUN  = 610;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = SLOTS + 8;
    localparam int HANDLE_POOL    = 48;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [FIELD_ADDR_W-1:0] ADDR_TOP = {FIELD_ADDR_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_MAX = 19'd262144;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [HANDLE_W-1:0]     handle;
        logic [FIELD_ADDR_W-1:0] rbase;
        logic [SIZE_W-1:0]       rsize;
        logic [FIELD_ADDR_W-1:0] qaddr;
        logic [LEN_W-1:0]        qlen;
    } command_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] owner;
        logic [COUNT_W-1:0]  count;
    } reply_t;

    typedef struct packed {
        command_t c;
        logic     typed;
        reply_t   r;
    } step_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // shadow of the region table
    logic [FIELD_ADDR_W-1:0] shadow_base  [SLOTS];
    logic [SIZE_W-1:0]       shadow_size  [SLOTS];
    logic [HANDLE_W-1:0]     shadow_owner [SLOTS];
    int                      shadow_count = 0;

    reply_t pending_replies[$];
    int     fail_count    = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     quiet_cycles  = 0;

    region_registry_lookup_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [S_TDATA_W-1:0] pack_command(command_t c);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[CMD_LSB +: CMD_W]           = c.cmd;
        d[HANDLE_LSB +: HANDLE_W]     = c.handle;
        d[RBASE_LSB +: FIELD_ADDR_W]  = c.rbase;
        d[RSIZE_LSB +: SIZE_W]        = c.rsize;
        d[QADDR_LSB +: FIELD_ADDR_W]  = c.qaddr;
        d[QLEN_LSB +: LEN_W]          = c.qlen;
        return d;
    endfunction

    function automatic logic region_covers(int i, logic [63:0] a, logic [63:0] len);
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] off;
        b = 64'(shadow_base[i]);
        s = 64'(shadow_size[i]);
        if (a < b) return 1'b0;
        off = a - b;
        if (off > s) return 1'b0;
        return len <= s - off;
    endfunction

    // applies one command to the shadow table and returns its reply
    function automatic reply_t apply_command(command_t c);
        reply_t      r;
        logic [63:0] a;
        logic [63:0] len;
        logic [63:0] stop;
        int          hit;
        r.status = ST_NOT_FOUND;
        r.owner  = '0;
        a    = 64'(c.qaddr);
        len  = 64'(c.qlen);
        stop = a + len;
        hit  = -1;
        case (c.cmd)
            CMD_ADD: begin
                if (c.handle == '0) begin
                    r.status = ST_BAD_HANDLE;
                end else if (shadow_count >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_base[shadow_count]  = c.rbase;
                    shadow_size[shadow_count]  = c.rsize;
                    shadow_owner[shadow_count] = c.handle;
                    shadow_count++;
                    r.status = ST_OK;
                end
            end
            CMD_REMOVE: begin
                if (c.handle == '0) begin
                    r.status = ST_BAD_HANDLE;
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        if (hit < 0 && shadow_owner[i] == c.handle) hit = i;
                    if (hit >= 0) begin
                        for (int j = hit; j + 1 < shadow_count; j++) begin
                            shadow_base[j]  = shadow_base[j + 1];
                            shadow_size[j]  = shadow_size[j + 1];
                            shadow_owner[j] = shadow_owner[j + 1];
                        end
                        shadow_count--;
                        r.status = ST_OK;
                    end
                end
            end
            CMD_FIND: begin
                if (a != 0 && (stop >> ADDR_BITS) == 0) begin
                    for (int i = 0; i < shadow_count; i++)
                        if (hit < 0 && region_covers(i, a, len)) hit = i;
                    if (hit >= 0) begin
                        r.status = ST_OK;
                        r.owner  = shadow_owner[hit];
                    end
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    function automatic logic [FIELD_ADDR_W-1:0] random_base();
        case ($urandom_range(3))
            0: return FIELD_ADDR_W'({$urandom, $urandom});
            1: return FIELD_ADDR_W'($urandom_range(0, 'hFFFF));
            2: return ADDR_TOP - FIELD_ADDR_W'($urandom_range(0, 300000));
            default: return FIELD_ADDR_W'(48'h1000_0000 + $urandom_range(0, 'h80000));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(5))
            0: return '0;
            1: return SIZE_MAX;
            2: return SIZE_W'($urandom_range(0, 64));
            default: return SIZE_W'($urandom_range(0, SIZE_MAX));
        endcase
    endfunction

    function automatic logic [HANDLE_W-1:0] random_handle();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85) return HANDLE_W'($urandom_range(1, HANDLE_POOL));
        if (pick < 92) return HANDLE_W'($urandom);
        if (pick < 95) return '1;
        return '0;
    endfunction

    // bias: 0 fills the table, 1 drains it, 2 mixed
    function automatic command_t random_command(int bias);
        command_t    c;
        int          pick;
        int          add_pct;
        int          rem_pct;
        int          i;
        logic [63:0] off;
        logic [63:0] room;
        c = '0;
        c.handle = HANDLE_W'($urandom);
        c.rbase  = random_base();
        c.rsize  = random_size();
        c.qaddr  = FIELD_ADDR_W'({$urandom, $urandom});
        c.qlen   = $urandom;
        add_pct  = (bias == 0) ? 65 : (bias == 1) ? 10 : 30;
        rem_pct  = (bias == 0) ? 10 : (bias == 1) ? 60 : 25;
        pick     = $urandom_range(99);
        if ($urandom_range(99) == 0) begin
            c.cmd = CMD_SPARE;
        end else if (pick < add_pct) begin
            c.cmd    = CMD_ADD;
            c.handle = random_handle();
        end else if (pick < add_pct + rem_pct) begin
            c.cmd = CMD_REMOVE;
            if (shadow_count > 0 && $urandom_range(99) < 70)
                c.handle = shadow_owner[$urandom_range(0, shadow_count - 1)];
            else
                c.handle = random_handle();
        end else begin
            c.cmd = CMD_FIND;
            if (shadow_count > 0 && $urandom_range(99) < 70) begin
                i    = $urandom_range(0, shadow_count - 1);
                off  = 64'($urandom_range(0, 32'(shadow_size[i])));
                room = 64'(shadow_size[i]) - off;
                c.qaddr = shadow_base[i] + FIELD_ADDR_W'(off);
                case ($urandom_range(3))
                    0: c.qlen = LEN_W'(room);
                    1: c.qlen = LEN_W'(room + 1);
                    2: c.qlen = '0;
                    default: c.qlen = LEN_W'($urandom_range(0, LEN_W'(room)));
                endcase
            end else begin
                case ($urandom_range(3))
                    0: c.qaddr = '0;
                    1: begin
                        c.qaddr = ADDR_TOP - FIELD_ADDR_W'($urandom_range(0, 1000));
                        c.qlen  = LEN_W'($urandom_range(0, 2000));
                    end
                    default: ;
                endcase
            end
        end
        return c;
    endfunction

    task automatic send_command(command_t c, logic typed, reply_t typed_reply);
        reply_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge aclk);
        end
        s_tdata  <= pack_command(c);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = apply_command(c);
        pending_replies.push_back(typed ? typed_reply : r);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[STATUS_LSB +: STATUS_W];
            got.owner  = m_tdata[OWNER_LSB +: HANDLE_W];
            got.count  = m_tdata[COUNT_LSB +: COUNT_W];
            if (pending_replies.size() == 0) begin
                fail_count++;
                $display("%0t unexpected transaction: status %0d owner %h count %0d",
                         $time, got.status, got.owner, got.count);
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status) begin
                    fail_count++;
                    $display("%0t status: expected %0d, actual %0d",
                             $time, want.status, got.status);
                end
                if (got.owner !== want.owner) begin
                    fail_count++;
                    $display("%0t owner_handle: expected %h, actual %h",
                             $time, want.owner, got.owner);
                end
                if (got.count !== want.count) begin
                    fail_count++;
                    $display("%0t entry_count: expected %0d, actual %0d",
                             $time, want.count, got.count);
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        step_t steps [24];
        steps = '{
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h1000, 32'h0}, 1'b1,
              '{ST_NOT_FOUND, 16'h0, 7'd0}},
            '{'{CMD_REMOVE, 16'h5, 48'h0, 19'h0, 48'h0, 32'h0}, 1'b1,
              '{ST_NOT_FOUND, 16'h0, 7'd0}},
            '{'{CMD_ADD, 16'h0, 48'h1000, 19'h10, 48'h0, 32'h0}, 1'b1,
              '{ST_BAD_HANDLE, 16'h0, 7'd0}},
            '{'{CMD_REMOVE, 16'h0, 48'h0, 19'h0, 48'h0, 32'h0}, 1'b1,
              '{ST_BAD_HANDLE, 16'h0, 7'd0}},
            '{'{CMD_ADD, 16'hFFFF, ADDR_TOP, SIZE_MAX, 48'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 7'd1}},
            '{'{CMD_ADD, 16'h1, 48'h0, 19'h0, 48'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 7'd2}},
            '{'{CMD_ADD, 16'h2, 48'h1000, 19'h100, 48'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 7'd3}},
            '{'{CMD_ADD, 16'h2, 48'h2000, SIZE_MAX, 48'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 7'd4}},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h1000, 32'h100}, 1'b1,
              '{ST_OK, 16'h2, 7'd4}},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h1100, 32'h0}, 1'b1,
              '{ST_OK, 16'h2, 7'd4}},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h1000, 32'h101}, 1'b0, '0},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h0, 32'h0}, 1'b1,
              '{ST_NOT_FOUND, 16'h0, 7'd4}},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, ADDR_TOP, 32'h1}, 1'b1,
              '{ST_NOT_FOUND, 16'h0, 7'd4}},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, ADDR_TOP, 32'h0}, 1'b1,
              '{ST_OK, 16'hFFFF, 7'd4}},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h1, 32'hFFFF_FFFF}, 1'b0, '0},
            '{'{CMD_SPARE, 16'h7, 48'h1000, 19'h10, 48'h1000, 32'h1}, 1'b1,
              '{ST_NOT_FOUND, 16'h0, 7'd4}},
            '{'{CMD_ADD, 16'h8000, 48'h7FFF_FFFF_FFFF, 19'h7, 48'h0, 32'h0}, 1'b0, '0},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h41FFF, 32'h1}, 1'b0, '0},
            '{'{CMD_REMOVE, 16'h2, 48'h0, 19'h0, 48'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 7'd4}},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h1000, 32'h10}, 1'b0, '0},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, 48'h2000, 32'h40000}, 1'b0, '0},
            '{'{CMD_REMOVE, 16'hFFFF, 48'h0, 19'h0, 48'h0, 32'h0}, 1'b0, '0},
            '{'{CMD_ADD, 16'h1234, 48'h0, 19'h1, 48'h0, 32'h0}, 1'b0, '0},
            '{'{CMD_FIND, 16'h0, 48'h0, 19'h0, ADDR_TOP, 32'hFFFF_FFFF}, 1'b0, '0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int run = 0; run < 3; run++) begin
            send_idle_pct = (run == 0) ? 20 : (run == 1) ? 52 : 0;
            recv_idle_pct = (run == 0) ? 52 : (run == 1) ? 20 : 0;
            if (run == 0)
                foreach (steps[k]) send_command(steps[k].c, steps[k].typed, steps[k].r);
            for (int n = 0; n < ITEMS_PER_RUN; n++)
                send_command(random_command((n / 120) % 3), 1'b0, '0);
            // hold the sender off until the table has answered everything
            drain_replies();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rrl_pkg.sv
rtl/rrl_cell.sv
rtl/region_registry_lookup_top.sv
test/region_registry_lookup_top_tb.sv
